/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_PROP(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr) \
	`ASSERT_PROP(label, !(expr))

`endif

/* hdl/i2cmbe_pkg.sv */
package i2cmbe_pkg;

	// Register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRETCH_LIMIT = 1'd1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd80;
	localparam logic [7:0] STRETCH_LIMIT_RESET = 8'd255;

	// Command codes
	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ = 3'd4;

	// Bit counter marks for the acknowledge slot
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [3:0] WRITE_TAIL = 4'd8;
	localparam logic [3:0] READ_TAIL = 4'd9;

	typedef enum logic [29:0] {
		PH_IDLE     = 30'h0000_0001,
		PH_S_SDAREL = 30'h0000_0002,
		PH_S_SCL    = 30'h0000_0004,
		PH_S_P1     = 30'h0000_0008,
		PH_S_SDALOW = 30'h0000_0010,
		PH_S_P2     = 30'h0000_0020,
		PH_S_SCLLOW = 30'h0000_0040,
		PH_P_SDALOW = 30'h0000_0080,
		PH_P_P1     = 30'h0000_0100,
		PH_P_SCL    = 30'h0000_0200,
		PH_P_P2     = 30'h0000_0400,
		PH_P_SDAREL = 30'h0000_0800,
		PH_P_P3     = 30'h0000_1000,
		PH_W_BIT    = 30'h0000_2000,
		PH_W_P1     = 30'h0000_4000,
		PH_W_SCL    = 30'h0000_8000,
		PH_W_P2     = 30'h0001_0000,
		PH_W_LOW    = 30'h0002_0000,
		PH_R_REL    = 30'h0004_0000,
		PH_R_P1     = 30'h0008_0000,
		PH_R_SCL    = 30'h0010_0000,
		PH_R_P2     = 30'h0020_0000,
		PH_R_SAMP   = 30'h0040_0000,
		PH_A_DRV    = 30'h0080_0000,
		PH_A_P1     = 30'h0100_0000,
		PH_A_SCL    = 30'h0200_0000,
		PH_A_P2     = 30'h0400_0000,
		PH_A_LOW    = 30'h0800_0000,
		PH_A_REL    = 30'h1000_0000,
		PH_A_P3     = 30'h2000_0000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  bit_count;
		logic [7:0]  shift_reg;
		logic [15:0] pause_count;
		logic [7:0]  stretch_count;
		logic        sda_drive;
		logic        scl_drive;
		logic        ack_mode;
		logic        ack_flag;
	} eng_state_t;

	typedef struct packed {
		logic [15:0] half_period_ticks;
		logic [7:0]  stretch_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] write_byte;
		logic       ack_after_read;
		logic       sda_level;
		logic       scl_level;
	} item_t;

	typedef struct packed {
		logic       ack_received;
		logic [7:0] read_data;
		logic       done_res;
		logic       busy_res;
		logic       scl_pull_low;
		logic       sda_pull_low;
	} result_t;

endpackage

/* hdl/i2c_master_byte_engine.sv */
// An accepted item is registered in the input stage and its result in the output register.
// Throughput: one item per cycle while m_axis is not stalled; each item is one bus tick,
// and the next tick needs the sequencer state written by this one.
// Reset (arst_n low, asynchronous): sequencer idle, both lines released, counters
// cleared, half period 80 ticks, stretch limit 255 ticks, no item held.
module i2c_master_byte_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [i2cmbe_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// write_byte[7:0], ack_after_read[8], sda_level[9], scl_level[10], zero[15:11]
	input  logic [15:0] s_axis_tdata,
	// command[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// sda_pull_low[0], scl_pull_low[1], busy_res[2], done_res[3],
	// read_data[11:4], ack_received[12], zero[15:13]
	output logic [15:0] m_axis_tdata
);

	i2cmbe_pkg::cfg_t       cfg_q;
	i2cmbe_pkg::eng_state_t state_q;
	i2cmbe_pkg::eng_state_t state_next;
	i2cmbe_pkg::item_t      item_s1;
	i2cmbe_pkg::result_t    res_next;
	i2cmbe_pkg::result_t    res_q;
	logic                   valid_s1;
	logic                   out_valid_q;
	logic                   advance;

	// Step the held item once the result register is free
	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= i2cmbe_pkg::HALF_PERIOD_RESET;
			cfg_q.stretch_limit <= i2cmbe_pkg::STRETCH_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cmbe_pkg::REG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_data;
				i2cmbe_pkg::REG_STRETCH_LIMIT: cfg_q.stretch_limit <= cfg_data[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Input stage: hold the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.command <= s_axis_tuser;
			item_s1.write_byte <= s_axis_tdata[7:0];
			item_s1.ack_after_read <= s_axis_tdata[8];
			item_s1.sda_level <= s_axis_tdata[9];
			item_s1.scl_level <= s_axis_tdata[10];
		end
	end

	i2cmbe_step u_step (
		.st      (state_q),
		.cfg     (cfg_q),
		.item    (item_s1),
		.st_next (state_next),
		.res     (res_next)
	);

	// Sequencer state: update once per stepped item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= i2cmbe_pkg::PH_IDLE;
			state_q.bit_count <= 4'd0;
			state_q.shift_reg <= 8'd0;
			state_q.pause_count <= 16'd0;
			state_q.stretch_count <= 8'd0;
			state_q.sda_drive <= 1'b0;
			state_q.scl_drive <= 1'b0;
			state_q.ack_mode <= 1'b0;
			state_q.ack_flag <= 1'b0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {3'd0, res_q.ack_received, res_q.read_data, res_q.done_res,
		res_q.busy_res, res_q.scl_pull_low, res_q.sda_pull_low};

endmodule

/* hdl/i2cmbe_step.sv */
module i2cmbe_step (
	input  i2cmbe_pkg::eng_state_t st,
	input  i2cmbe_pkg::cfg_t       cfg,
	input  i2cmbe_pkg::item_t      item,
	output i2cmbe_pkg::eng_state_t st_next,
	output i2cmbe_pkg::result_t    res
);

	logic [16:0] pause_sum;
	logic        pause_end;
	logic [15:0] pause_next;
	logic        rel_done;
	logic [7:0]  stretch_next;
	logic        scl_rel_next;
	logic [3:0]  bit_inc;
	logic        done;
	logic [7:0]  rdata;

	// Pause tick: end when the count reaches the half period
	assign pause_sum = {1'b0, st.pause_count} + 17'd1;
	assign pause_end = (pause_sum >= {1'b0, cfg.half_period_ticks});
	assign pause_next = pause_end ? 16'd0 : pause_sum[15:0];

	// Clock release: drop the drive first, then wait for SCL high or the limit
	assign rel_done = !st.scl_drive &&
		(item.scl_level || (st.stretch_count >= cfg.stretch_limit));
	assign scl_rel_next = 1'b0;
	assign stretch_next = (st.scl_drive || rel_done) ? 8'd0 : st.stretch_count + 8'd1;

	assign bit_inc = st.bit_count + 4'd1;

	// Advance the sequencer by one tick
	always_comb begin
		st_next = st;
		done = 1'b0;
		rdata = 8'd0;
		case (st.phase)
			i2cmbe_pkg::PH_IDLE: begin
				st_next.pause_count = 16'd0;
				st_next.stretch_count = 8'd0;
				case (item.command)
					i2cmbe_pkg::CMD_START: st_next.phase = i2cmbe_pkg::PH_S_SDAREL;
					i2cmbe_pkg::CMD_STOP: st_next.phase = i2cmbe_pkg::PH_P_SDALOW;
					i2cmbe_pkg::CMD_WRITE: begin
						st_next.shift_reg = item.write_byte;
						st_next.bit_count = 4'd0;
						st_next.ack_mode = 1'b0;
						st_next.phase = i2cmbe_pkg::PH_W_BIT;
					end
					i2cmbe_pkg::CMD_READ: begin
						st_next.shift_reg = 8'd0;
						st_next.bit_count = 4'd0;
						st_next.ack_mode = item.ack_after_read;
						st_next.phase = i2cmbe_pkg::PH_R_REL;
					end
					default: st_next.phase = i2cmbe_pkg::PH_IDLE;
				endcase
			end
			// start condition
			i2cmbe_pkg::PH_S_SDAREL: begin
				st_next.sda_drive = 1'b0;
				st_next.phase = i2cmbe_pkg::PH_S_SCL;
			end
			i2cmbe_pkg::PH_S_SCL: begin
				st_next.scl_drive = scl_rel_next;
				st_next.stretch_count = stretch_next;
				if (rel_done) st_next.phase = i2cmbe_pkg::PH_S_P1;
			end
			i2cmbe_pkg::PH_S_P1: begin
				st_next.pause_count = pause_next;
				if (pause_end) st_next.phase = i2cmbe_pkg::PH_S_SDALOW;
			end
			i2cmbe_pkg::PH_S_SDALOW: begin
				st_next.sda_drive = 1'b1;
				st_next.phase = i2cmbe_pkg::PH_S_P2;
			end
			i2cmbe_pkg::PH_S_P2: begin
				st_next.pause_count = pause_next;
				if (pause_end) st_next.phase = i2cmbe_pkg::PH_S_SCLLOW;
			end
			i2cmbe_pkg::PH_S_SCLLOW: begin
				st_next.scl_drive = 1'b1;
				st_next.phase = i2cmbe_pkg::PH_IDLE;
				done = 1'b1;
			end
			// stop condition
			i2cmbe_pkg::PH_P_SDALOW: begin
				st_next.sda_drive = 1'b1;
				st_next.phase = i2cmbe_pkg::PH_P_P1;
			end
			i2cmbe_pkg::PH_P_P1: begin
				st_next.pause_count = pause_next;
				if (pause_end) st_next.phase = i2cmbe_pkg::PH_P_SCL;
			end
			i2cmbe_pkg::PH_P_SCL: begin
				st_next.scl_drive = scl_rel_next;
				st_next.stretch_count = stretch_next;
				if (rel_done) st_next.phase = i2cmbe_pkg::PH_P_P2;
			end
			i2cmbe_pkg::PH_P_P2: begin
				st_next.pause_count = pause_next;
				if (pause_end) st_next.phase = i2cmbe_pkg::PH_P_SDAREL;
			end
			i2cmbe_pkg::PH_P_SDAREL: begin
				st_next.sda_drive = 1'b0;
				st_next.phase = i2cmbe_pkg::PH_P_P3;
			end
			i2cmbe_pkg::PH_P_P3: begin
				st_next.pause_count = pause_next;
				if (pause_end) begin
					st_next.phase = i2cmbe_pkg::PH_IDLE;
					done = 1'b1;
				end
			end
			// write bits, MSB first
			i2cmbe_pkg::PH_W_BIT: begin
				st_next.sda_drive = !st.shift_reg[7];
				st_next.phase = i2cmbe_pkg::PH_W_P1;
			end
			i2cmbe_pkg::PH_W_P1: begin
				st_next.pause_count = pause_next;
				if (pause_end) st_next.phase = i2cmbe_pkg::PH_W_SCL;
			end
			i2cmbe_pkg::PH_W_SCL: begin
				st_next.scl_drive = scl_rel_next;
				st_next.stretch_count = stretch_next;
				if (rel_done) st_next.phase = i2cmbe_pkg::PH_W_P2;
			end
			i2cmbe_pkg::PH_W_P2: begin
				st_next.pause_count = pause_next;
				if (pause_end) st_next.phase = i2cmbe_pkg::PH_W_LOW;
			end
			i2cmbe_pkg::PH_W_LOW: begin
				st_next.scl_drive = 1'b1;
				st_next.shift_reg = {st.shift_reg[6:0], 1'b0};
				if (bit_inc >= i2cmbe_pkg::BITS_PER_BYTE) begin
					st_next.bit_count = i2cmbe_pkg::WRITE_TAIL;
					st_next.phase = i2cmbe_pkg::PH_A_DRV;
				end else begin
					st_next.bit_count = bit_inc;
					st_next.phase = i2cmbe_pkg::PH_W_BIT;
				end
			end
			// read bits, MSB first
			i2cmbe_pkg::PH_R_REL: begin
				st_next.sda_drive = 1'b0;
				st_next.phase = i2cmbe_pkg::PH_R_P1;
			end
			i2cmbe_pkg::PH_R_P1: begin
				st_next.pause_count = pause_next;
				if (pause_end) st_next.phase = i2cmbe_pkg::PH_R_SCL;
			end
			i2cmbe_pkg::PH_R_SCL: begin
				st_next.scl_drive = scl_rel_next;
				st_next.stretch_count = stretch_next;
				if (rel_done) st_next.phase = i2cmbe_pkg::PH_R_P2;
			end
			i2cmbe_pkg::PH_R_P2: begin
				st_next.pause_count = pause_next;
				if (pause_end) st_next.phase = i2cmbe_pkg::PH_R_SAMP;
			end
			i2cmbe_pkg::PH_R_SAMP: begin
				st_next.shift_reg = {st.shift_reg[6:0], item.sda_level};
				st_next.scl_drive = 1'b1;
				if (bit_inc >= i2cmbe_pkg::BITS_PER_BYTE) begin
					st_next.bit_count = i2cmbe_pkg::READ_TAIL;
					st_next.phase = i2cmbe_pkg::PH_A_DRV;
				end else begin
					st_next.bit_count = bit_inc;
					st_next.phase = i2cmbe_pkg::PH_R_P1;
				end
			end
			// acknowledge slot
			i2cmbe_pkg::PH_A_DRV: begin
				st_next.sda_drive = st.ack_mode;
				st_next.phase = i2cmbe_pkg::PH_A_P1;
			end
			i2cmbe_pkg::PH_A_P1: begin
				st_next.pause_count = pause_next;
				if (pause_end) st_next.phase = i2cmbe_pkg::PH_A_SCL;
			end
			i2cmbe_pkg::PH_A_SCL: begin
				st_next.scl_drive = scl_rel_next;
				st_next.stretch_count = stretch_next;
				if (rel_done) st_next.phase = i2cmbe_pkg::PH_A_P2;
			end
			i2cmbe_pkg::PH_A_P2: begin
				st_next.pause_count = pause_next;
				if (pause_end) st_next.phase = i2cmbe_pkg::PH_A_LOW;
			end
			i2cmbe_pkg::PH_A_LOW: begin
				st_next.scl_drive = 1'b1;
				if (st.bit_count == i2cmbe_pkg::WRITE_TAIL) begin
					st_next.ack_flag = !item.sda_level;
					st_next.phase = i2cmbe_pkg::PH_A_P3;
				end else begin
					st_next.phase = i2cmbe_pkg::PH_A_REL;
				end
			end
			i2cmbe_pkg::PH_A_REL: begin
				st_next.sda_drive = 1'b0;
				st_next.phase = i2cmbe_pkg::PH_A_P3;
			end
			i2cmbe_pkg::PH_A_P3: begin
				st_next.pause_count = pause_next;
				if (pause_end) begin
					st_next.phase = i2cmbe_pkg::PH_IDLE;
					done = 1'b1;
					if (st.bit_count == i2cmbe_pkg::READ_TAIL) rdata = st.shift_reg;
				end
			end
			default: st_next.phase = i2cmbe_pkg::PH_IDLE;
		endcase
	end

	// Build the result item from the updated state
	always_comb begin
		res.sda_pull_low = st_next.sda_drive;
		res.scl_pull_low = st_next.scl_drive;
		res.busy_res = (st_next.phase != i2cmbe_pkg::PH_IDLE);
		res.done_res = done;
		res.read_data = rdata;
		res.ack_received = st_next.ack_flag;
	end

endmodule

/* hdl/i2cmbe_checker.sv */
`include "assert_macros.svh"

module i2cmbe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// A stalled result stays put
	`ASSERT_PROP(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

	// Input side only stalls behind a blocked result
	`ASSERT_PROP(a_in_stall, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))

	// A completing command is no longer busy
	`ASSERT_NEVER(a_done_busy, m_axis_tvalid && m_axis_tdata[3] && m_axis_tdata[2])

	// Read data only shows on a done tick
	`ASSERT_NEVER(a_rdata_done, m_axis_tvalid && (m_axis_tdata[11:4] != 8'd0) && !m_axis_tdata[3])

endmodule

bind i2c_master_byte_engine i2cmbe_checker u_i2cmbe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
